// ===== rtl/core/dafa_pkg.sv =====
`timescale 1ns / 1ps
package dafa_pkg;

  localparam int ANGLE_FRAC_BITS = 14;
  localparam int CORDIC_STAGES   = 16;
  localparam int WFRAC           = 30;
  localparam int SHIFT           = WFRAC - ANGLE_FRAC_BITS;

  // internal Q.30 values, signed
  localparam int QW = 36;

  localparam logic signed [QW-1:0] Q_ONE     = 36'sd1073741824;
  localparam logic signed [QW-1:0] Q_PI      = 36'sd3373259426;
  localparam logic signed [QW-1:0] Q_HALF_PI = 36'sd1686629713;
  localparam logic signed [QW-1:0] Q_TWO_PI  = 36'sd6746518852;
  localparam logic signed [QW-1:0] Q_GAIN    = 36'sd652032874;

  // division and square root run one result bit per stage
  localparam int DIV_BITS  = 31;
  localparam int SQRT_BITS = 31;

  function automatic logic signed [QW-1:0] atan_lut(input int i);
    logic signed [QW-1:0] v;
    begin
      case (i)
        0:  v = 36'sd843314856;
        1:  v = 36'sd497837829;
        2:  v = 36'sd263043836;
        3:  v = 36'sd133525158;
        4:  v = 36'sd67021686;
        5:  v = 36'sd33543515;
        6:  v = 36'sd16775850;
        7:  v = 36'sd8388437;
        8:  v = 36'sd4194282;
        9:  v = 36'sd2097149;
        10: v = 36'sd1048575;
        11: v = 36'sd524287;
        12: v = 36'sd262143;
        13: v = 36'sd131071;
        14: v = 36'sd65535;
        15: v = 36'sd32767;
        16: v = 36'sd16383;
        17: v = 36'sd8191;
        18: v = 36'sd4095;
        19: v = 36'sd2047;
        20: v = 36'sd1023;
        21: v = 36'sd511;
        22: v = 36'sd255;
        23: v = 36'sd127;
        24: v = 36'sd63;
        25: v = 36'sd31;
        26: v = 36'sd15;
        27: v = 36'sd8;
        28: v = 36'sd4;
        29: v = 36'sd2;
        30: v = 36'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/core/dihedral_angle_from_face_angles.sv =====
`timescale 1ns / 1ps
// Path: front, rotation CORDIC, products, divider, square root, vectoring CORDIC, output register.
// Throughput: one beat per cycle; every stage is a register stage of one add/compare or
// one narrow multiply, and the whole pipeline advances together when the output can drain.
// The output register accepts a new beat whenever it is empty or being read.
// Reset: synchronous active-low rst_n clears every valid bit; payload registers are not reset.
module dihedral_angle_from_face_angles (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // face_angle_a[15:0], face_angle_b[31:16], face_angle_c[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // dihedral_angle[15:0]
  output logic [1:0]  out_tuser   // degenerate[0], clamped[1]
);

  localparam int QW = dafa_pkg::QW;
  localparam int NS = dafa_pkg::CORDIC_STAGES;
  localparam int ND = dafa_pkg::DIV_BITS;
  localparam int NR = dafa_pkg::SQRT_BITS;
  localparam int PW = 64;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [PW-1:0] p_t;

  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- front: reduce and fold ----------------
  logic       f0_v_r;
  q_t         f0_t_r [3];

  logic       rc_v_r [NS+1];
  q_t         rc_x_r [NS+1][3];
  q_t         rc_y_r [NS+1][3];
  q_t         rc_t_r [NS+1][3];
  logic [2:0] rc_f_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r    <= 1'b0;
      rc_v_r[0] <= 1'b0;
    end else if (adv) begin
      f0_v_r    <= in_tvalid;
      rc_v_r[0] <= f0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        // value < 2*2pi, one subtract reduces it modulo 2pi
        logic signed [QW-1:0] t, tr;
        t  = q_t'({4'd0, in_tdata[16*k +: 16], 16'd0}) >>> (16 - dafa_pkg::SHIFT);
        tr = (t >= dafa_pkg::Q_TWO_PI) ? t - dafa_pkg::Q_TWO_PI : t;
        f0_t_r[k] <= (tr > dafa_pkg::Q_PI) ? tr - dafa_pkg::Q_TWO_PI : tr;
      end
      for (int k = 0; k < 3; k++) begin
        rc_x_r[0][k] <= dafa_pkg::Q_GAIN;
        rc_y_r[0][k] <= '0;
        if (f0_t_r[k] > dafa_pkg::Q_HALF_PI) begin
          rc_t_r[0][k] <= dafa_pkg::Q_PI - f0_t_r[k];
          rc_f_r[0][k] <= 1'b1;
        end else if (f0_t_r[k] < -dafa_pkg::Q_HALF_PI) begin
          rc_t_r[0][k] <= -dafa_pkg::Q_PI - f0_t_r[k];
          rc_f_r[0][k] <= 1'b1;
        end else begin
          rc_t_r[0][k] <= f0_t_r[k];
          rc_f_r[0][k] <= 1'b0;
        end
      end
    end
  end

  // ---------------- rotation CORDIC, three lanes ----------------
  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!rst_n) rc_v_r[i+1] <= 1'b0;
      else if (adv) rc_v_r[i+1] <= rc_v_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rc_f_r[i+1] <= rc_f_r[i];
        for (int k = 0; k < 3; k++) begin
          if (rc_t_r[i][k] >= 0) begin
            rc_x_r[i+1][k] <= rc_x_r[i][k] - (rc_y_r[i][k] >>> i);
            rc_y_r[i+1][k] <= rc_y_r[i][k] + (rc_x_r[i][k] >>> i);
            rc_t_r[i+1][k] <= rc_t_r[i][k] - dafa_pkg::atan_lut(i);
          end else begin
            rc_x_r[i+1][k] <= rc_x_r[i][k] + (rc_y_r[i][k] >>> i);
            rc_y_r[i+1][k] <= rc_y_r[i][k] - (rc_x_r[i][k] >>> i);
            rc_t_r[i+1][k] <= rc_t_r[i][k] + dafa_pkg::atan_lut(i);
          end
        end
      end
    end
  end

  // ---------------- products ----------------
  function automatic logic [QW-1:0] amag(input q_t v);
    return v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

  logic m0_v_r, m1_v_r;
  logic [QW-1:0] m0_ca_r, m0_cb_r, m0_sa_r, m0_sb_r;
  logic m0_nc_r, m0_ns_r;
  q_t   m0_cc_r;
  p_t   m1_pc_r, m1_ps_r;
  logic m1_nc_r, m1_ns_r;
  q_t   m1_cc_r;
  logic m2_v_r;
  q_t   m2_num_r, m2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_v_r <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (adv) begin
      m0_v_r <= rc_v_r[NS];
      m1_v_r <= m0_v_r;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_t ca, cb;
      ca = rc_f_r[NS][0] ? -rc_x_r[NS][0] : rc_x_r[NS][0];
      cb = rc_f_r[NS][1] ? -rc_x_r[NS][1] : rc_x_r[NS][1];
      m0_ca_r <= amag(ca);
      m0_cb_r <= amag(cb);
      m0_nc_r <= ca[QW-1] ^ cb[QW-1];
      m0_sa_r <= amag(rc_y_r[NS][0]);
      m0_sb_r <= amag(rc_y_r[NS][1]);
      m0_ns_r <= rc_y_r[NS][0][QW-1] ^ rc_y_r[NS][1][QW-1];
      m0_cc_r <= rc_f_r[NS][2] ? -rc_x_r[NS][2] : rc_x_r[NS][2];
      // magnitudes stay below 2^31
      m1_pc_r <= PW'(m0_ca_r[31:0]) * PW'(m0_cb_r[31:0]);
      m1_ps_r <= PW'(m0_sa_r[31:0]) * PW'(m0_sb_r[31:0]);
      m1_nc_r <= m0_nc_r;
      m1_ns_r <= m0_ns_r;
      m1_cc_r <= m0_cc_r;
      begin
        q_t pc, ps;
        pc = q_t'(m1_pc_r >> dafa_pkg::WFRAC);
        ps = q_t'(m1_ps_r >> dafa_pkg::WFRAC);
        m2_num_r <= m1_cc_r - (m1_nc_r ? -pc : pc);
        m2_den_r <= m1_ns_r ? -ps : ps;
      end
    end
  end

  // ---------------- classify, restoring divider: q = (nm << 30) / dm ----------------
  localparam int RW = QW + 1;
  logic          dv_v_r   [ND+1];
  logic [RW-1:0] dv_rem_r [ND+1];
  logic [ND-1:0] dv_q_r   [ND+1];
  logic [QW-1:0] dv_dm_r  [ND+1];
  logic [2:0]    dv_fl_r  [ND+1];
  logic          dv_lsb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= m2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      logic [QW-1:0] nm, dm;
      nm = amag(m2_num_r);
      dm = amag(m2_den_r);
      // dividend bits above the first quotient bit preload the remainder
      dv_rem_r[0] <= RW'(nm >> 1);
      dv_lsb_r    <= nm[0];
      dv_q_r[0]   <= '0;
      dv_dm_r[0]  <= dm;
      dv_fl_r[0]  <= {m2_num_r[QW-1] ^ m2_den_r[QW-1], nm > dm,
                      dm < (QW'(1) << dafa_pkg::SHIFT)};
    end
  end

  for (genvar i = 0; i < ND; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[i+1] <= 1'b0;
      else if (adv) dv_v_r[i+1] <= dv_v_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        logic [RW-1:0] tr;
        // only the first stage takes a dividend bit, nm[0]; the rest shift in zeros
        tr = {dv_rem_r[i][RW-2:0], (i == 0) ? dv_lsb_r : 1'b0};
        if (tr >= {1'b0, dv_dm_r[i]}) begin
          dv_rem_r[i+1] <= tr - {1'b0, dv_dm_r[i]};
          dv_q_r[i+1]   <= dv_q_r[i] | (ND'(1) << (ND-1-i));
        end else begin
          dv_rem_r[i+1] <= tr;
          dv_q_r[i+1]   <= dv_q_r[i];
        end
        dv_dm_r[i+1] <= dv_dm_r[i];
        dv_fl_r[i+1] <= dv_fl_r[i];
      end
    end
  end

  // ---------------- r and 1 - r^2 ----------------
  logic        s0_v_r;
  logic [2:0]  s0_fl_r;
  q_t          s0_r_r;
  logic [30:0] s0_rm_r;

  logic        sq_v_r   [NR+1];
  logic [61:0] sq_n_r   [NR+1];
  logic [62:0] sq_res_r [NR+1];
  q_t          sq_r_r   [NR+1];
  logic [2:0]  sq_fl_r  [NR+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r    <= 1'b0;
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      s0_v_r    <= dv_v_r[ND];
      sq_v_r[0] <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      logic [30:0] q;
      q = dv_fl_r[ND][1] ? 31'(dafa_pkg::Q_ONE) : dv_q_r[ND];
      s0_rm_r <= q;
      s0_r_r  <= dv_fl_r[ND][2] ? -q_t'({5'd0, q}) : q_t'({5'd0, q});
      s0_fl_r <= dv_fl_r[ND];
      sq_n_r[0]   <= (62'd1 << 60) - 62'(s0_rm_r) * 62'(s0_rm_r);
      sq_res_r[0] <= '0;
      sq_r_r[0]   <= s0_r_r;
      sq_fl_r[0]  <= s0_fl_r;
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  for (genvar i = 0; i < NR; i++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'd1 << (60 - 2*i);
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[i+1] <= 1'b0;
      else if (adv) sq_v_r[i+1] <= sq_v_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if ({1'b0, sq_n_r[i]} >= sq_res_r[i] + BIT) begin
          sq_n_r[i+1]   <= 62'({1'b0, sq_n_r[i]} - (sq_res_r[i] + BIT));
          sq_res_r[i+1] <= (sq_res_r[i] >> 1) + BIT;
        end else begin
          sq_n_r[i+1]   <= sq_n_r[i];
          sq_res_r[i+1] <= sq_res_r[i] >> 1;
        end
        sq_r_r[i+1]  <= sq_r_r[i];
        sq_fl_r[i+1] <= sq_fl_r[i];
      end
    end
  end

  // ---------------- vectoring CORDIC ----------------
  logic       vc_v_r  [NS+1];
  q_t         vc_x_r  [NS+1];
  q_t         vc_y_r  [NS+1];
  q_t         vc_z_r  [NS+1];
  logic [1:0] vc_fl_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vc_v_r[0] <= 1'b0;
    else if (adv) vc_v_r[0] <= sq_v_r[NR];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_t s;
      s = q_t'(sq_res_r[NR][31:0]);
      if (sq_r_r[NR][QW-1]) begin
        vc_x_r[0] <= s;
        vc_y_r[0] <= -sq_r_r[NR];
        vc_z_r[0] <= dafa_pkg::Q_HALF_PI;
      end else begin
        vc_x_r[0] <= sq_r_r[NR];
        vc_y_r[0] <= s;
        vc_z_r[0] <= '0;
      end
      vc_fl_r[0] <= sq_fl_r[NR][1:0];
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (!rst_n) vc_v_r[i+1] <= 1'b0;
      else if (adv) vc_v_r[i+1] <= vc_v_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vc_y_r[i] > 0) begin
          vc_x_r[i+1] <= vc_x_r[i] + (vc_y_r[i] >>> i);
          vc_y_r[i+1] <= vc_y_r[i] - (vc_x_r[i] >>> i);
          vc_z_r[i+1] <= vc_z_r[i] + dafa_pkg::atan_lut(i);
        end else begin
          vc_x_r[i+1] <= vc_x_r[i] - (vc_y_r[i] >>> i);
          vc_y_r[i+1] <= vc_y_r[i] + (vc_x_r[i] >>> i);
          vc_z_r[i+1] <= vc_z_r[i] - dafa_pkg::atan_lut(i);
        end
        vc_fl_r[i+1] <= vc_fl_r[i];
      end
    end
  end

  // ---------------- output register ----------------
  logic        out_v_r;
  logic [15:0] out_ang_r;
  logic [1:0]  out_usr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= vc_v_r[NS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      logic [QW-1:0] v;
      v = vc_z_r[NS][QW-1] ? '0 :
          (QW'(vc_z_r[NS]) + (QW'(1) << (dafa_pkg::SHIFT - 1))) >> dafa_pkg::SHIFT;
      if (vc_fl_r[NS][0]) begin
        out_ang_r <= '0;
        out_usr_r <= 2'b01;
      end else begin
        out_ang_r <= (v > QW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
        out_usr_r <= {vc_fl_r[NS][1], 1'b0};
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_ang_r;
  assign out_tuser  = out_usr_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed under stall");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("degenerate and clamped both set");
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 16'd0)
    else $error("degenerate result not zero");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vc_v_r[NS] |=> out_tvalid)
    else $error("beat lost at output");

endmodule
